### hw/rtl/tile_matrix_multiply_accumulate_macros.svh
// Assertion macros shared by the tile multiply-accumulate RTL.
// No dependencies; included by the files that carry assertions.
`ifndef TILE_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH
`define TILE_MATRIX_MULTIPLY_ACCUMULATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TMMA_ASSERT_IMP(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TMMA_ASSERT_NXT(lbl, c, r, a, b) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
		else $error("next-cycle check failed");

`endif

### hw/rtl/tmma_pkg.sv
// Types and constants of the tile multiply-accumulate block.
// No dependencies; used by the interfaces and all modules.
package tmma_pkg;

	localparam int TILE      = 8;
	localparam int IDX_BITS  = 3;
	localparam int ELEM_BITS = 16;
	localparam int PROD_BITS = 2 * ELEM_BITS;
	localparam int ACC_BITS  = 48;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_LOAD   = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef logic [IDX_BITS-1:0]         idx_t;
	typedef logic signed [ELEM_BITS-1:0] elem_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;
	typedef logic signed [ACC_BITS-1:0]  acc_t;

	// Control that travels with an item down the pipeline.
	typedef struct packed {
		logic    valid;
		action_t act;
	} stage_ctl_t;

endpackage

### hw/rtl/tmma_cmd_if.sv
// Command channel: action, index and one A or B row.
// Depends on tmma_pkg.
interface tmma_cmd_if import tmma_pkg::*; ();
	logic    valid;
	logic    ready;
	action_t action;
	idx_t    index;
	elem_t   e0;
	elem_t   e1;
	elem_t   e2;
	elem_t   e3;
	elem_t   e4;
	elem_t   e5;
	elem_t   e6;
	elem_t   e7;

	modport source (output valid, action, index, e0, e1, e2, e3, e4, e5, e6, e7,
		input ready);
	modport sink (input valid, action, index, e0, e1, e2, e3, e4, e5, e6, e7,
		output ready);
endinterface

### hw/rtl/tmma_res_if.sv
// Result channel: one accumulator row per transfer.
// Depends on tmma_pkg.
interface tmma_res_if import tmma_pkg::*; ();
	logic valid;
	logic ready;
	idx_t row;
	logic last;
	acc_t c0;
	acc_t c1;
	acc_t c2;
	acc_t c3;
	acc_t c4;
	acc_t c5;
	acc_t c6;
	acc_t c7;

	modport source (output valid, row, last, c0, c1, c2, c3, c4, c5, c6, c7,
		input ready);
	modport sink (input valid, row, last, c0, c1, c2, c3, c4, c5, c6, c7,
		output ready);
endinterface

### hw/rtl/tmma_mac_array.sv
// 8x8 array of multiply-accumulate cells with saturating accumulators.
// Depends on tmma_pkg.
module tmma_mac_array import tmma_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  stage_ctl_t ctl_s1,
	input  elem_t      a_col [TILE],
	input  elem_t      b_row [TILE],
	output stage_ctl_t ctl_s2,
	input  idx_t       rd_row,
	output acc_t       rd_data [TILE]
);

	localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
	localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

	prod_t p_s2  [TILE][TILE];
	acc_t  acc_q [TILE][TILE];

	function automatic acc_t sat_add(acc_t acc, prod_t p);
		logic signed [ACC_BITS:0] sum;
		sum = {acc[ACC_BITS-1], acc} + {{(ACC_BITS+1-PROD_BITS){p[PROD_BITS-1]}}, p};
		if (sum[ACC_BITS] != sum[ACC_BITS-1]) begin
			return sum[ACC_BITS] ? ACC_MIN : ACC_MAX;
		end
		return sum[ACC_BITS-1:0];
	endfunction

	// Products of A column k and B row, one per cell.
	always_ff @(posedge clk) begin
		if (ctl_s1.valid && ctl_s1.act == ACT_UPDATE) begin
			for (int i = 0; i < TILE; i++) begin
				for (int j = 0; j < TILE; j++) begin
					p_s2[i][j] <= prod_t'(a_col[i] * b_row[j]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '{valid: 1'b0, act: ACT_CLEAR};
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TILE; i++) begin
				for (int j = 0; j < TILE; j++) begin
					acc_q[i][j] <= '0;
				end
			end
		end else if (ctl_s2.valid && ctl_s2.act == ACT_CLEAR) begin
			for (int i = 0; i < TILE; i++) begin
				for (int j = 0; j < TILE; j++) begin
					acc_q[i][j] <= '0;
				end
			end
		end else if (ctl_s2.valid && ctl_s2.act == ACT_UPDATE) begin
			for (int i = 0; i < TILE; i++) begin
				for (int j = 0; j < TILE; j++) begin
					acc_q[i][j] <= sat_add(acc_q[i][j], p_s2[i][j]);
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < TILE; j++) begin
			rd_data[j] = acc_q[rd_row][j];
		end
	end

endmodule

### hw/rtl/tile_matrix_multiply_accumulate.sv
// Top level of the 8x8 tile multiply-accumulate engine.
// Depends on tmma_pkg, tmma_cmd_if, tmma_res_if, tmma_mac_array and the macro header.
//
// Usage:
//   cmd carries one action per transfer: clear the accumulators, load A row
//   <index>, rank-1 update with B row <index> (C[i][j] += A[i][index]*e_j,
//   saturated at 48 bits), or read out. A read out sends 8 transfers on res,
//   rows 0..7 in order, last set on row 7; the accumulators are kept.
// Throughput: clear, load and update are accepted back to back, one per cycle,
//   while no read out is pending. A read out holds cmd.ready low from its
//   acceptance until row 7 sits in the result register; the row sequencer
//   walks the accumulator read port one row a cycle while res.ready allows.
// Pipeline: an item is registered (s1), its 64 products are registered (s2),
//   then it lands in the accumulators. A read out passes s1 and s2, starts
//   the row sequencer, and row 0 then goes through the result register to res.
// Stall: a low res.ready holds a valid result register and pauses the row
//   sequencer; the pipeline never drops or repeats a row.
// Reset: arst_n clears the accumulators and all control. The A tile is not
//   reset and must be loaded before an update uses it.
`include "tile_matrix_multiply_accumulate_macros.svh"

module tile_matrix_multiply_accumulate import tmma_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	tmma_cmd_if.sink   cmd,
	tmma_res_if.source res
);

	localparam idx_t LAST_ROW = idx_t'(TILE - 1);

	// Stage 1: registered command.
	logic       valid_s1;
	action_t    act_s1;
	idx_t       index_s1;
	elem_t      e_s1 [TILE];
	stage_ctl_t ctl_s1;
	stage_ctl_t ctl_s2;

	// A tile, written by loads, read one column at a time by updates.
	elem_t a_q   [TILE][TILE];
	elem_t a_col [TILE];

	// Read out sequencer and result register.
	logic  reading_q;
	idx_t  rd_row_q;
	acc_t  rd_data [TILE];
	logic  load_out;
	logic  res_valid_q;
	idx_t  res_row_q;
	logic  res_last_q;
	acc_t  res_c_q [TILE];
	logic  cmd_xfer;

	// A read out anywhere in the pipeline blocks new commands, so it sees
	// every earlier update and no later one.
	assign cmd.ready = !reading_q
		&& !(valid_s1 && act_s1 == ACT_READ)
		&& !(ctl_s2.valid && ctl_s2.act == ACT_READ);
	assign cmd_xfer = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			act_s1   <= cmd.action;
			index_s1 <= cmd.index;
			e_s1[0]  <= cmd.e0;
			e_s1[1]  <= cmd.e1;
			e_s1[2]  <= cmd.e2;
			e_s1[3]  <= cmd.e3;
			e_s1[4]  <= cmd.e4;
			e_s1[5]  <= cmd.e5;
			e_s1[6]  <= cmd.e6;
			e_s1[7]  <= cmd.e7;
		end
	end

	assign ctl_s1 = '{valid: valid_s1, act: act_s1};

	// Load writes at the end of s1, so an update right behind reads the new row.
	always_ff @(posedge clk) begin
		if (valid_s1 && act_s1 == ACT_LOAD) begin
			for (int j = 0; j < TILE; j++) begin
				a_q[index_s1][j] <= e_s1[j];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < TILE; i++) begin
			a_col[i] = a_q[i][index_s1];
		end
	end

	tmma_mac_array u_mac_array (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.a_col   (a_col),
		.b_row   (e_s1),
		.ctl_s2  (ctl_s2),
		.rd_row  (rd_row_q),
		.rd_data (rd_data)
	);

	assign load_out = reading_q && (!res_valid_q || res.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reading_q <= 1'b0;
			rd_row_q  <= '0;
		end else if (ctl_s2.valid && ctl_s2.act == ACT_READ) begin
			reading_q <= 1'b1;
			rd_row_q  <= '0;
		end else if (load_out) begin
			rd_row_q <= rd_row_q + idx_t'(1);
			if (rd_row_q == LAST_ROW) begin
				reading_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_row_q  <= rd_row_q;
			res_last_q <= (rd_row_q == LAST_ROW);
			for (int j = 0; j < TILE; j++) begin
				res_c_q[j] <= rd_data[j];
			end
		end
	end

	assign res.valid = res_valid_q;
	assign res.row   = res_row_q;
	assign res.last  = res_last_q;
	assign res.c0    = res_c_q[0];
	assign res.c1    = res_c_q[1];
	assign res.c2    = res_c_q[2];
	assign res.c3    = res_c_q[3];
	assign res.c4    = res_c_q[4];
	assign res.c5    = res_c_q[5];
	assign res.c6    = res_c_q[6];
	assign res.c7    = res_c_q[7];

	`TMMA_ASSERT_IMP(a_no_cmd_while_reading, clk, arst_n, reading_q, !cmd.ready)
	`TMMA_ASSERT_NXT(a_read_starts_sequencer, clk, arst_n,
		ctl_s2.valid && ctl_s2.act == ACT_READ, reading_q && rd_row_q == '0)
	`TMMA_ASSERT_NXT(a_row_follows_sequencer, clk, arst_n, load_out,
		res.valid && res.row == $past(rd_row_q))
	`TMMA_ASSERT_IMP(a_last_on_final_row, clk, arst_n, res.valid && res.last,
		res.row == LAST_ROW)

endmodule
